>>> sv/octs_pkg.sv
`default_nettype none

package octs_pkg;

	// Default coordinate width and the depth of the command queue.
	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	// Width of the offset registers.
	localparam int OFFSET_BITS = 16;

	// Characters that the scanner and the printer care about.
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Configuration register indexes.
	localparam logic CFG_X_OFFSET = 1'b0;
	localparam logic CFG_Y_OFFSET = 1'b1;

	// Work handed from the scanner to the printer.
	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_NUM,
		CMD_TERM
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] text;
		logic term;
	} cmd_t;

	// Number of decimal digits needed for the largest value of a given width.
	function automatic int dec_digits(input int bits);
		logic [63:0] v;
		int n;
		begin
			v = (64'd1 << bits) - 64'd1;
			n = 0;
			for (int i = 0; i < 20; i++) begin
				if (v != 64'd0) begin
					n = n + 1;
					v = v / 64'd10;
				end
			end
			dec_digits = (n == 0) ? 1 : n;
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/octs_queue.sv
`default_nettype none

module octs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire logic [WIDTH-1:0] wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth; the count tracks the fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/octs_front.sv
`default_nettype none

module octs_front #(
	parameter int COORD_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [octs_pkg::OFFSET_BITS-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	output logic push_valid,
	input wire logic push_ready,
	output octs_pkg::cmd_t push_cmd,
	output logic [COORD_BITS-1:0] push_value
);

	import octs_pkg::*;

	localparam int CW = (COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS;
	localparam int AW = COORD_BITS + 4;

	typedef enum logic [1:0] {
		M_SKIP,
		M_DIGITS,
		M_TAIL,
		M_TEXT
	} mode_t;

	mode_t mode_q, mode_d;
	logic [COORD_BITS-1:0] num_q, num_d;
	logic y_q, y_d;
	logic [OFFSET_BITS-1:0] x_off_q;
	logic [OFFSET_BITS-1:0] y_off_q;

	logic accept;
	logic is_digit;
	logic is_gap;
	logic [3:0] dval;
	logic [AW-1:0] num_wide;
	logic [AW-1:0] acc;
	logic [COORD_BITS-1:0] acc_sat;
	logic [CW-1:0] num_ext;
	logic [CW-1:0] off_ext;
	logic [CW-1:0] diff;
	logic [COORD_BITS-1:0] clamped;
	logic push_req;
	cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign in_ready = push_ready;
	assign accept = in_valid && in_ready;

	// Character classes.
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_gap = (in_byte == CH_SPACE) || (in_byte == CH_NL);
	assign dval = in_byte[3:0];

	// Decimal accumulation, saturating at the largest coordinate.
	assign num_wide = AW'(num_q);
	assign acc = (num_wide << 3) + (num_wide << 1) + AW'(dval);
	assign acc_sat = (acc[AW-1:COORD_BITS] != '0) ? '1 : acc[COORD_BITS-1:0];

	// Offset subtraction with the result clamped at zero.
	assign num_ext = CW'(num_q);
	assign off_ext = CW'(y_q ? y_off_q : x_off_q);
	assign diff = num_ext - off_ext;
	assign clamped = (num_ext > off_ext) ? diff[COORD_BITS-1:0] : '0;

	// Scanner: decide the next mode and the command this item produces.
	always_comb begin
		mode_d = mode_q;
		num_d = num_q;
		y_d = y_q;
		push_req = 1'b0;
		cmd.kind = CMD_BYTE;
		cmd.text = in_byte;
		cmd.term = 1'b0;
		if (in_byte == CH_NUL) begin
			push_req = 1'b1;
			cmd.term = 1'b1;
			unique case (mode_q)
				M_DIGITS, M_TAIL: cmd.kind = CMD_NUM;
				M_TEXT: begin
					cmd.kind = CMD_BYTE;
					cmd.text = CH_NL;
				end
				default: cmd.kind = CMD_TERM;
			endcase
			mode_d = M_SKIP;
			num_d = '0;
			y_d = 1'b0;
		end else begin
			unique case (mode_q)
				M_SKIP: begin
					if (!is_gap) begin
						if (is_digit) begin
							num_d = COORD_BITS'(dval);
							mode_d = M_DIGITS;
						end else begin
							push_req = 1'b1;
							mode_d = M_TEXT;
						end
					end
				end
				M_DIGITS, M_TAIL: begin
					if (in_byte == CH_SPACE) begin
						push_req = 1'b1;
						cmd.kind = CMD_NUM;
						num_d = '0;
						y_d = !y_q;
						mode_d = M_SKIP;
					end else if (mode_q == M_DIGITS) begin
						if (is_digit) begin
							num_d = acc_sat;
						end else begin
							mode_d = M_TAIL;
						end
					end
				end
				M_TEXT: begin
					push_req = 1'b1;
					if (in_byte == CH_NL) begin
						y_d = 1'b0;
						mode_d = M_SKIP;
					end
				end
				default: mode_d = M_SKIP;
			endcase
		end
	end

	assign push_valid = accept && push_req;
	assign push_cmd = cmd;
	assign push_value = clamped;

	// Scanner state and the offset registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
			num_q <= '0;
			y_q <= 1'b0;
			x_off_q <= '0;
			y_off_q <= '0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				num_q <= num_d;
				y_q <= y_d;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_X_OFFSET: x_off_q <= cfg_data;
					CFG_Y_OFFSET: y_off_q <= cfg_data;
					default: x_off_q <= x_off_q;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/octs_back.sv
`default_nettype none

module octs_back #(
	parameter int COORD_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire octs_pkg::cmd_t cmd,
	input wire logic [COORD_BITS-1:0] cmd_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic out_last
);

	import octs_pkg::*;

	localparam int MAXD = dec_digits(COORD_BITS);
	localparam int DIDX = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int CNTW = $clog2(MAXD + 1);
	localparam int SHIFT = COORD_BITS + 3;
	localparam int QW = COORD_BITS - 3;
	localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd9) / 64'd10;
	localparam logic [COORD_BITS-1:0] RECIP = RECIP_FULL[COORD_BITS-1:0];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIGIT,
		ST_SPACE,
		ST_TERM
	} state_t;

	state_t state_q;
	logic [COORD_BITS-1:0] val_q;
	logic [CNTW-1:0] cnt_q;
	logic [3:0] dig_q [MAXD];
	logic term_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic slot_free;
	logic out_load;
	logic [2*COORD_BITS-1:0] prod;
	logic [QW-1:0] quot;
	logic [COORD_BITS-1:0] quot_ext;
	logic [COORD_BITS-1:0] rem_full;
	logic [CNTW-1:0] cnt_m1;

	// The output register can take a new item once the current one is gone.
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	// The sequencer loads a new item into the output register this cycle.
	assign out_load = (state_q == ST_IDLE) ?
		(cmd_valid && cmd_ready && (cmd.kind != CMD_NUM)) :
		((state_q == ST_DIGIT || state_q == ST_SPACE || state_q == ST_TERM) && slot_free);

	// One decimal digit per cycle: divide by ten through the reciprocal.
	assign prod = val_q * RECIP;
	assign quot = prod[2*COORD_BITS-1:SHIFT];
	assign quot_ext = COORD_BITS'(quot);
	assign rem_full = val_q - ((quot_ext << 3) + (quot_ext << 1));
	assign cnt_m1 = cnt_q - 1'b1;

	// Commands are taken in the idle state; numbers go off to the converter.
	always_comb begin
		cmd_ready = 1'b0;
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_ready = (cmd.kind == CMD_NUM) || slot_free;
		end
	end

	// Printer sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			val_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < MAXD; i++) begin
				dig_q[i] <= '0;
			end
			term_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						term_q <= cmd.term;
						if (cmd.kind == CMD_NUM) begin
							val_q <= cmd_value;
							cnt_q <= '0;
							state_q <= ST_CONV;
						end else if (cmd.kind == CMD_TERM) begin
							out_valid_q <= 1'b1;
							out_byte_q <= CH_NUL;
							out_last_q <= 1'b1;
						end else begin
							out_valid_q <= 1'b1;
							out_byte_q <= cmd.text;
							out_last_q <= 1'b0;
							if (cmd.term) begin
								state_q <= ST_TERM;
							end
						end
					end
				end
				ST_CONV: begin
					dig_q[cnt_q[DIDX-1:0]] <= rem_full[3:0];
					cnt_q <= cnt_q + 1'b1;
					val_q <= quot_ext;
					if (quot_ext == '0) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q <= CH_ZERO + {4'd0, dig_q[cnt_m1[DIDX-1:0]]};
						out_last_q <= 1'b0;
						cnt_q <= cnt_m1;
						if (cnt_q == CNTW'(1)) begin
							state_q <= ST_SPACE;
						end
					end
				end
				ST_SPACE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q <= CH_SPACE;
						out_last_q <= 1'b0;
						state_q <= term_q ? ST_TERM : ST_IDLE;
					end
				end
				ST_TERM: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q <= CH_NUL;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/outline_text_coordinate_shifter.sv
`default_nettype none

// Rewrites outline text one byte per item and shifts its coordinates. Number
// tokens are read as decimal (saturating at 2^COORD_BITS - 1), reduced by the
// X or the Y offset in turn, clamped at zero and printed again followed by a
// space; other tokens pass through up to their newline, which restarts at X.
// A 0 byte ends the set: any pending token is flushed and a 0 item with tlast
// follows. Input bytes are taken one per cycle into a four-entry command
// queue while it has room; text bytes leave one per cycle while m_tready is
// high; a number is first converted one decimal digit per cycle in the
// divide-by-ten converter, then its digits and a space are sent; the
// printer takes no new item while it converts and prints a number. Offsets
// are written through the cfg channel, which is always ready; the user must
// write them only while the block is idle: the block does not enforce this.
module outline_text_coordinate_shifter #(
	parameter int COORD_BITS = octs_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [octs_pkg::OFFSET_BITS-1:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] in_byte
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // [7:0] out_byte
	output logic m_tlast
);

	import octs_pkg::*;

	localparam int QW = $bits(cmd_t) + COORD_BITS;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic [COORD_BITS-1:0] push_value;
	logic [QW-1:0] rd_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;
	logic [COORD_BITS-1:0] pop_value;

	// Scanner: classifies bytes and holds the offsets.
	octs_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd),
		.push_value(push_value)
	);

	// Command queue between the scanner and the printer.
	octs_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data({push_value, push_cmd}),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data(rd_data)
	);

	assign pop_cmd = rd_data[$bits(cmd_t)-1:0];
	assign pop_value = rd_data[QW-1:$bits(cmd_t)];

	// Printer: converts numbers and drives the output stream.
	octs_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd(pop_cmd),
		.cmd_value(pop_value),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte(m_tdata),
		.out_last(m_tlast)
	);

endmodule

`default_nettype wire
